@@ hdl/c39_pkg.sv @@
// shared types, constants and the 3-of-9 pattern table for the code 39 encoder
// no dependencies
package c39_pkg;

	localparam int BARS_PER_CHAR   = 5;
	localparam int SPACES_PER_CHAR = 4;
	localparam int ELEMS_PER_CHAR  = BARS_PER_CHAR + SPACES_PER_CHAR;
	localparam int IDX_W           = $clog2(ELEMS_PER_CHAR + 1);

	localparam logic [IDX_W-1:0] ELEM_LAST_IDX = IDX_W'(ELEMS_PER_CHAR - 1);
	localparam logic [IDX_W-1:0] GAP_IDX       = IDX_W'(ELEMS_PER_CHAR);

	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] LOWER_A      = 8'h61;
	localparam logic [7:0] LOWER_Z      = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam logic [ELEMS_PER_CHAR-1:0] STAR_PATTERN = 9'h094;

	// configuration register indexes
	localparam logic REG_NARROW = 1'b0;
	localparam logic REG_WIDE   = 1'b1;

	typedef enum logic [2:0] {
		SEG_START = 3'b001,
		SEG_CHAR  = 3'b010,
		SEG_STOP  = 3'b100
	} seg_t;

	typedef struct packed {
		logic                      has_start;
		logic                      has_char;
		logic                      bad;
		logic                      has_stop;
		logic [ELEMS_PER_CHAR-1:0] pattern;
	} job_t;

	// wide/narrow mask, first element in the top bit; zero when unsupported
	function automatic logic [ELEMS_PER_CHAR-1:0] pattern_of(input logic [7:0] c);
		logic [ELEMS_PER_CHAR-1:0] p;
		begin
			case (c)
				8'h30: p = 9'h034; 8'h31: p = 9'h121; 8'h32: p = 9'h061;
				8'h33: p = 9'h160; 8'h34: p = 9'h031; 8'h35: p = 9'h130;
				8'h36: p = 9'h070; 8'h37: p = 9'h025; 8'h38: p = 9'h124;
				8'h39: p = 9'h064; 8'h41: p = 9'h109; 8'h42: p = 9'h049;
				8'h43: p = 9'h148; 8'h44: p = 9'h019; 8'h45: p = 9'h118;
				8'h46: p = 9'h058; 8'h47: p = 9'h00D; 8'h48: p = 9'h10C;
				8'h49: p = 9'h04C; 8'h4A: p = 9'h01C; 8'h4B: p = 9'h103;
				8'h4C: p = 9'h043; 8'h4D: p = 9'h142; 8'h4E: p = 9'h013;
				8'h4F: p = 9'h112; 8'h50: p = 9'h052; 8'h51: p = 9'h007;
				8'h52: p = 9'h106; 8'h53: p = 9'h046; 8'h54: p = 9'h016;
				8'h55: p = 9'h181; 8'h56: p = 9'h0C1; 8'h57: p = 9'h1C0;
				8'h58: p = 9'h091; 8'h59: p = 9'h190; 8'h5A: p = 9'h0D0;
				CHAR_MINUS:   p = 9'h085;
				8'h2E:        p = 9'h184;
				8'h20:        p = 9'h0C4;
				CHAR_STAR:    p = STAR_PATTERN;
				CHAR_DOLLAR:  p = 9'h0A8;
				8'h2F:        p = 9'h0A2;
				8'h2B:        p = 9'h08A;
				CHAR_PERCENT: p = 9'h02A;
				default:      p = '0;
			endcase
			return p;
		end
	endfunction

endpackage

@@ hdl/c39_front.sv @@
// input stage: case folding, pattern lookup and start/stop bookkeeping
// depends on c39_pkg
module c39_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_code,
	input  logic          last_char,
	output logic          job_valid,
	output c39_pkg::job_t job,
	input  logic          job_take
);

	logic          start_sent_q;
	logic          job_v_s1;
	c39_pkg::job_t job_s1;
	c39_pkg::job_t job_next;
	logic [7:0]    char_up;
	logic          accept;
	logic          any_result;

	always_comb begin
		char_up = char_code;
		if (char_code inside {[c39_pkg::LOWER_A:c39_pkg::LOWER_Z]}) begin
			char_up = char_code - c39_pkg::CASE_OFFSET;
		end
		job_next.pattern   = c39_pkg::pattern_of(char_up);
		job_next.has_start = !start_sent_q;
		// a data star gives nothing of its own
		job_next.has_char  = (char_up != c39_pkg::CHAR_STAR);
		job_next.bad       = (job_next.pattern == '0);
		job_next.has_stop  = last_char;
	end

	assign any_result = job_next.has_start | job_next.has_char | job_next.has_stop;
	assign in_ready   = !job_v_s1 || job_take;
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sent_q <= 1'b0;
			job_v_s1     <= 1'b0;
		end else if (accept) begin
			start_sent_q <= !last_char;
			job_v_s1     <= any_result;
		end else if (job_take) begin
			job_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_next;
		end
	end

	assign job_valid = job_v_s1;
	assign job       = job_s1;

endmodule

@@ hdl/c39_serial.sv @@
// element sequencer: walks start, character and stop, one element a cycle unless the output stalls
// depends on c39_pkg
module c39_serial (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  c39_pkg::job_t job,
	output logic          job_take,
	input  logic [7:0]    narrow_w,
	input  logic [7:0]    wide_w,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          is_bar,
	output logic          is_wide,
	output logic [7:0]    elem_width,
	output logic          bad_char,
	output logic          run_end,
	output logic          symbol_end
);

	logic                               active_q;
	c39_pkg::seg_t                      seg_q;
	logic [c39_pkg::IDX_W-1:0]          idx_q;
	c39_pkg::job_t                      cur_q;
	logic                               out_valid_q;

	logic [c39_pkg::ELEMS_PER_CHAR-1:0] pat_sel;
	logic [c39_pkg::IDX_W-1:0]          bit_idx;
	logic                               in_char;
	logic                               elem_bad;
	logic                               elem_bar;
	logic                               elem_wide;
	logic                               seg_last;
	logic                               more;
	c39_pkg::seg_t                      seg_next;
	c39_pkg::seg_t                      seg_first;
	logic                               job_last;
	logic                               out_free;
	logic                               step;

	always_comb begin
		in_char  = (seg_q == c39_pkg::SEG_CHAR);
		pat_sel  = in_char ? cur_q.pattern : c39_pkg::STAR_PATTERN;
		elem_bad = in_char && cur_q.bad;
		bit_idx  = (idx_q <= c39_pkg::ELEM_LAST_IDX) ? (c39_pkg::ELEM_LAST_IDX - idx_q) : '0;
		elem_bar  = !elem_bad && (idx_q != c39_pkg::GAP_IDX) && !idx_q[0];
		elem_wide = !elem_bad && (idx_q != c39_pkg::GAP_IDX) && pat_sel[bit_idx];
		seg_last  = elem_bad || (idx_q == c39_pkg::GAP_IDX);

		more     = 1'b0;
		seg_next = c39_pkg::SEG_STOP;
		case (seg_q)
			c39_pkg::SEG_START: begin
				more     = cur_q.has_char || cur_q.has_stop;
				seg_next = cur_q.has_char ? c39_pkg::SEG_CHAR : c39_pkg::SEG_STOP;
			end
			c39_pkg::SEG_CHAR: begin
				more     = cur_q.has_stop;
				seg_next = c39_pkg::SEG_STOP;
			end
			default: begin
				more     = 1'b0;
				seg_next = c39_pkg::SEG_STOP;
			end
		endcase
		job_last = seg_last && !more;

		if (job.has_start) begin
			seg_first = c39_pkg::SEG_START;
		end else if (job.has_char) begin
			seg_first = c39_pkg::SEG_CHAR;
		end else begin
			seg_first = c39_pkg::SEG_STOP;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign step     = active_q && out_free;
	assign job_take = job_valid && (!active_q || (step && job_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			seg_q    <= c39_pkg::SEG_START;
			idx_q    <= '0;
		end else if (job_take) begin
			active_q <= 1'b1;
			seg_q    <= seg_first;
			idx_q    <= '0;
		end else if (step) begin
			if (seg_last) begin
				idx_q <= '0;
				if (more) begin
					seg_q <= seg_next;
				end else begin
					active_q <= 1'b0;
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			cur_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			is_bar     <= elem_bar;
			is_wide    <= elem_wide;
			elem_width <= elem_bad ? 8'd0 : (elem_wide ? wide_w : narrow_w);
			bad_char   <= elem_bad;
			run_end    <= job_last;
			symbol_end <= (seg_q == c39_pkg::SEG_STOP) && (idx_q == c39_pkg::GAP_IDX);
		end
	end

	assign out_valid = out_valid_q;

	a_stop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && symbol_end |-> run_end)
		else $error("stop gap not flagged as end of run");

	a_bad_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_char |-> !is_bar && !is_wide && (elem_width == 8'd0))
		else $error("error result carries element fields");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= c39_pkg::GAP_IDX))
		else $error("element index past the gap");

	a_bad_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && elem_bad |=> (seg_q != c39_pkg::SEG_CHAR) || !active_q || (idx_q == '0))
		else $error("error character gave more than one result");

endmodule

@@ hdl/code39_element_encoder.sv @@
// code 39 element encoder top level: configuration registers, input stage, sequencer
// depends on c39_pkg, c39_front, c39_serial
// path: input stage register, sequencer job register, then the registered element output
// throughput: one element per cycle from the sequencer unless the output stalls;
// 10 elements per character, 10 for the start, 10 for the stop, 1 for an unsupported one
// reset: asynchronous, clears all control state; widths return to 1 and 3
module code39_element_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_bar,
	output logic       is_wide,
	output logic [7:0] elem_width,
	output logic       bad_char,
	output logic       run_end,
	output logic       symbol_end
);

	logic [7:0]    narrow_width_q;
	logic [7:0]    wide_width_q;
	logic          job_valid;
	logic          job_take;
	c39_pkg::job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_width_q <= 8'd1;
			wide_width_q   <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				c39_pkg::REG_NARROW: narrow_width_q <= cfg_data;
				c39_pkg::REG_WIDE:   wide_width_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	c39_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	c39_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.job_take   (job_take),
		.narrow_w   (narrow_width_q),
		.wide_w     (wide_width_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_bar     (is_bar),
		.is_wide    (is_wide),
		.elem_width (elem_width),
		.bad_char   (bad_char),
		.run_end    (run_end),
		.symbol_end (symbol_end)
	);

endmodule

@@ dv/code39_element_check.sv @@
// result checker for the code 39 element encoder: predicts the element stream
// from input transfers and compares every output transfer field by field
// depends on c39_pkg for register indexes and character constants
`timescale 1ns / 1ps
module code39_element_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       is_bar,
	input  logic       is_wide,
	input  logic [7:0] elem_width,
	input  logic       bad_char,
	input  logic       run_end,
	input  logic       symbol_end,
	output int         fail_count,
	output int         pending,
	output int         checked
);

	// wide/narrow masks, first element in the top bit, listed in character order
	localparam logic [10*9-1:0] DIGIT_MASKS = {
		9'h034, 9'h121, 9'h061, 9'h160, 9'h031,
		9'h130, 9'h070, 9'h025, 9'h124, 9'h064
	};
	localparam logic [26*9-1:0] LETTER_MASKS = {
		9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C,
		9'h01C, 9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106,
		9'h046, 9'h016, 9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0
	};

	typedef struct packed {
		logic       bar;
		logic       wide;
		logic [7:0] dots;
		logic       bad;
		logic       run_done;
		logic       sym_done;
	} elem_t;

	elem_t      step_elems[$];
	elem_t      awaited_elems[$];
	elem_t      want;
	logic [7:0] narrow_dots;
	logic [7:0] wide_dots;
	logic       in_message;

	function automatic logic [8:0] glyph_mask(input logic [7:0] c);
		int idx;
		logic [8:0] m;
		m = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			idx = int'(c) - 'h30;
			m = DIGIT_MASKS[(9 - idx) * 9 +: 9];
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			idx = int'(c) - 'h41;
			m = LETTER_MASKS[(25 - idx) * 9 +: 9];
		end else begin
			case (c)
				c39_pkg::CHAR_MINUS:   m = 9'h085;
				8'h2E:                 m = 9'h184;
				8'h20:                 m = 9'h0C4;
				c39_pkg::CHAR_STAR:    m = 9'h094;
				c39_pkg::CHAR_DOLLAR:  m = 9'h0A8;
				8'h2F:                 m = 9'h0A2;
				8'h2B:                 m = 9'h08A;
				c39_pkg::CHAR_PERCENT: m = 9'h02A;
				default:               m = '0;
			endcase
		end
		return m;
	endfunction

	function automatic elem_t make_elem(input logic bar, input logic wide, input logic bad);
		elem_t e;
		e.bar      = bar;
		e.wide     = wide;
		e.dots     = bad ? 8'd0 : (wide ? wide_dots : narrow_dots);
		e.bad      = bad;
		e.run_done = 1'b0;
		e.sym_done = 1'b0;
		return e;
	endfunction

	// nine elements, bar first, then the narrow gap between characters
	task automatic stage_glyph(input logic [8:0] mask);
		for (int e = 0; e < c39_pkg::ELEMS_PER_CHAR; e++)
			step_elems.push_back(make_elem(e % 2 == 0,
				mask[c39_pkg::ELEMS_PER_CHAR - 1 - e], 1'b0));
		step_elems.push_back(make_elem(1'b0, 1'b0, 1'b0));
	endtask

	task automatic predict_elements(input logic [7:0] code, input logic fin);
		logic [7:0] c;
		logic [8:0] m;
		step_elems.delete();
		if (!in_message) begin
			stage_glyph(glyph_mask(c39_pkg::CHAR_STAR));
			in_message = 1'b1;
		end
		c = code;
		if (c >= c39_pkg::LOWER_A && c <= c39_pkg::LOWER_Z)
			c = c - c39_pkg::CASE_OFFSET;
		// a star inside the message produces nothing of its own
		if (c != c39_pkg::CHAR_STAR) begin
			m = glyph_mask(c);
			if (m == '0)
				step_elems.push_back(make_elem(1'b0, 1'b0, 1'b1));
			else
				stage_glyph(m);
		end
		if (fin) begin
			stage_glyph(glyph_mask(c39_pkg::CHAR_STAR));
			step_elems[step_elems.size() - 1].sym_done = 1'b1;
			in_message = 1'b0;
		end
		if (step_elems.size() > 0)
			step_elems[step_elems.size() - 1].run_done = 1'b1;
		foreach (step_elems[i])
			awaited_elems.push_back(step_elems[i]);
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_elems.delete();
			narrow_dots = 8'd1;
			wide_dots   = 8'd3;
			in_message  = 1'b0;
			fail_count  = 0;
			checked     = 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == c39_pkg::REG_NARROW)
					narrow_dots = cfg_data;
				else
					wide_dots = cfg_data;
			end
			if (in_valid && in_ready)
				predict_elements(char_code, last_char);
			if (out_valid && out_ready) begin
				if (awaited_elems.size() == 0) begin
					$error("element transfer with nothing expected");
					fail_count++;
				end else begin
					want = awaited_elems.pop_front();
					check_field("is_bar", want.bar, is_bar);
					check_field("is_wide", want.wide, is_wide);
					check_field("elem_width", want.dots, elem_width);
					check_field("bad_char", want.bad, bad_char);
					check_field("run_end", want.run_done, run_end);
					check_field("symbol_end", want.sym_done, symbol_end);
					checked++;
				end
			end
			pending <= awaited_elems.size();
		end
	end

endmodule

@@ dv/tb_code39_element_encoder.sv @@
// top of the code 39 encoder testbench: clock, reset, width settings, character
// stimulus, output back-pressure, watchdog and verdict
// depends on c39_pkg, code39_element_encoder and code39_element_check
`timescale 1ns / 1ps
module tb_code39_element_encoder;

	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_CHARS   = 40;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = c39_pkg::REG_NARROW;
	logic [7:0] cfg_data  = 8'd0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'd0;
	logic       last_char = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_bar;
	logic       is_wide;
	logic [7:0] elem_width;
	logic       bad_char;
	logic       run_end;
	logic       symbol_end;

	int fail_count;
	int pending;
	int checked;
	int send_idle     = 0;
	int recv_stall    = 0;
	int hold_left     = 0;
	int quiet         = 0;
	int chars_sent    = 0;
	int messages_sent = 0;
	int settings_used = 0;

	always #5 clk = ~clk;

	code39_element_encoder u_top (.*);
	code39_element_check u_check (.*);

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] code, input logic fin);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= code;
		last_char <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
		if (fin)
			messages_sent++;
	endtask

	// widths may only change once every element has come out
	task automatic drain_and_pause();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_widths(input logic [7:0] narrow, input logic [7:0] wide);
		cfg_we    <= 1'b1;
		cfg_index <= c39_pkg::REG_NARROW;
		cfg_data  <= narrow;
		@(posedge clk);
		cfg_index <= c39_pkg::REG_WIDE;
		cfg_data  <= wide;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// mostly encodable text, some stars and some arbitrary bytes
	function automatic logic [7:0] pick_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 25)
			c = 8'h41 + 8'($urandom_range(25));
		else if (r < 40)
			c = c39_pkg::LOWER_A + 8'($urandom_range(25));
		else if (r < 60)
			c = 8'h30 + 8'($urandom_range(9));
		else if (r < 75) begin
			case ($urandom_range(6))
				0:       c = c39_pkg::CHAR_MINUS;
				1:       c = 8'h2E;
				2:       c = 8'h20;
				3:       c = c39_pkg::CHAR_DOLLAR;
				4:       c = 8'h2F;
				5:       c = 8'h2B;
				default: c = c39_pkg::CHAR_PERCENT;
			endcase
		end else if (r < 83)
			c = c39_pkg::CHAR_STAR;
		else
			c = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic send_message(input int max_len);
		int len;
		len = $urandom_range(1, max_len);
		for (int i = 0; i < len; i++)
			send_char(pick_char(), i == len - 1);
	endtask

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset widths, every character class and the awkward corners
		send_char(8'h41, 1'b1);
		send_char(c39_pkg::CHAR_STAR, 1'b1);     // star alone: only start and stop
		send_char(8'h61, 1'b0);
		send_char(8'h7A, 1'b0);
		send_char(8'h30, 1'b0);
		send_char(8'h39, 1'b0);
		send_char(8'h5A, 1'b0);
		send_char(c39_pkg::CHAR_STAR, 1'b0);     // star mid-message gives nothing
		send_char(c39_pkg::CHAR_MINUS, 1'b0);
		send_char(8'h2E, 1'b0);
		send_char(8'h20, 1'b0);
		send_char(c39_pkg::CHAR_DOLLAR, 1'b0);
		send_char(8'h2F, 1'b0);
		send_char(8'h2B, 1'b0);
		send_char(c39_pkg::CHAR_PERCENT, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(c39_pkg::CHAR_STAR, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'h7F, 1'b0);
		send_char(8'h60, 1'b0);
		send_char(8'h7B, 1'b0);
		send_char(8'h40, 1'b1);              // unsupported character ends the message

		for (int p = 0; p < 8; p++) begin
			drain_and_pause();
			case (p)
				0:       set_widths(8'd1, 8'd3);
				1:       set_widths(8'd255, 8'd255);
				2:       set_widths(8'd0, 8'd0);
				3:       set_widths(8'd1, 8'd255);
				4:       set_widths(8'd255, 8'd1);
				default: set_widths(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
			endcase
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 80; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 80; end
				default: begin send_idle = 25; recv_stall = 25; end
			endcase
			// output held off while characters keep coming, so the input backs up
			if (p == 4)
				hold_left = HOLD_CYCLES;
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target)
				send_message(8);
		end

		drain_and_pause();
		$display("encoded %0d characters in %0d messages, %0d elements checked",
			chars_sent, messages_sent, checked);
		$display("%0d width settings, zero and full-scale widths among them", settings_used);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ code39_element_encoder.f @@
hdl/c39_pkg.sv
hdl/c39_front.sv
hdl/c39_serial.sv
hdl/code39_element_encoder.sv
dv/code39_element_check.sv
dv/tb_code39_element_encoder.sv
